>>> design/decimal_fixed_point_alu_macros.svh
// ----------------------------------------------------------------------------
// Decimal fixed-point ALU assertion macros
// Shared property wrappers clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_FIXED_POINT_ALU_MACROS_SVH
`define DECIMAL_FIXED_POINT_ALU_MACROS_SVH

// Same-cycle implication
`define DFPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DFPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dfpa_pkg.sv
// ----------------------------------------------------------------------------
// Decimal fixed-point ALU package
// Operation codes, result selects, divider widths and the sideband word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfpa_pkg;

    // Divider widths: dividend magnitude, divisor magnitude, kept quotient bits
    localparam int NUM_W = 64;
    localparam int DEN_W = 35;
    localparam int QUO_W = 32;

    typedef enum logic [3:0] {
        MODE_ADD    = 4'd0,
        MODE_SUB    = 4'd1,
        MODE_MUL    = 4'd2,
        MODE_DIV    = 4'd3,
        MODE_MOD    = 4'd4,
        MODE_NEG    = 4'd5,
        MODE_EQ     = 4'd6,
        MODE_LT     = 4'd7,
        MODE_TO_INT = 4'd8,
        MODE_TO_DEC = 4'd9
    } mode_t;

    typedef enum logic [1:0] {
        SEL_SIMPLE = 2'd0,
        SEL_QUOT   = 2'd1,
        SEL_REM    = 2'd2
    } sel_t;

    // Control that travels alongside the divider
    typedef struct packed {
        sel_t        sel;
        logic        round_en;
        logic        num_neg;
        logic        den_neg;
        logic        err;
        logic        rdec;
        logic [31:0] simple;
    } side_t;

endpackage

`default_nettype wire

>>> design/dfpa_div.sv
// ----------------------------------------------------------------------------
// Decimal fixed-point ALU divider
// Restoring unsigned divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfpa_div (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     ce,
    input  wire logic                     in_valid,
    input  wire logic [dfpa_pkg::NUM_W-1:0] in_num,
    input  wire logic [dfpa_pkg::DEN_W-1:0] in_den,
    input  wire dfpa_pkg::side_t          in_side,
    output logic                          out_valid,
    output logic [dfpa_pkg::QUO_W-1:0]    out_quot,
    output logic [dfpa_pkg::DEN_W-1:0]    out_rem,
    output logic [dfpa_pkg::DEN_W-1:0]    out_den,
    output dfpa_pkg::side_t               out_side
);

    localparam int NW = dfpa_pkg::NUM_W;
    localparam int DW = dfpa_pkg::DEN_W;
    localparam int QW = dfpa_pkg::QUO_W;

    logic                  valid_reg [1:NW];
    logic [NW-1:0]         num_reg   [1:NW];
    logic [DW-1:0]         den_reg   [1:NW];
    logic [DW-1:0]         rem_reg   [1:NW];
    logic [QW-1:0]         quot_reg  [1:NW];
    dfpa_pkg::side_t       side_reg  [1:NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic            valid_src;
        logic [NW-1:0]   num_src;
        logic [DW-1:0]   den_src;
        logic [DW-1:0]   rem_src;
        logic [QW-1:0]   quot_src;
        dfpa_pkg::side_t side_src;
        logic [DW:0]     trial;
        logic            fits;
        logic [DW:0]     diff;
        logic [DW-1:0]   rem_next;

        if (i == 0) begin : g_first
            assign valid_src = in_valid;
            assign num_src   = in_num;
            assign den_src   = in_den;
            assign rem_src   = '0;
            assign quot_src  = '0;
            assign side_src  = in_side;
        end else begin : g_rest
            assign valid_src = valid_reg[i];
            assign num_src   = num_reg[i];
            assign den_src   = den_reg[i];
            assign rem_src   = rem_reg[i];
            assign quot_src  = quot_reg[i];
            assign side_src  = side_reg[i];
        end

        // Bring down the next dividend bit and try the subtract
        always_comb begin
            trial    = {rem_src, num_src[NW-1]};
            fits     = trial >= {1'b0, den_src};
            diff     = trial - {1'b0, den_src};
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (ce) begin
                valid_reg[i+1] <= valid_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                num_reg[i+1]  <= {num_src[NW-2:0], 1'b0};
                den_reg[i+1]  <= den_src;
                rem_reg[i+1]  <= rem_next;
                quot_reg[i+1] <= {quot_src[QW-2:0], fits};
                side_reg[i+1] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[NW];
    assign out_quot  = quot_reg[NW];
    assign out_rem   = rem_reg[NW];
    assign out_den   = den_reg[NW];
    assign out_side  = side_reg[NW];

endmodule

`default_nettype wire

>>> design/decimal_fixed_point_alu.sv
// Decimal fixed-point ALU. Each word carries a mode and two 32-bit operands,
// each tagged as integer or as decimal scaled by SCALE; one result word comes
// back per input word, in order. A new word can enter every cycle while
// s_axis_tready is high. Stages: four setup (capture, scaling, one shared 32x32
// multiplier with operand select, magnitude), 64 of the bit-serial divider (one
// quotient bit each, used for decimal mul/div rounding, div, mod and to_int),
// one sign and rounding stage and the output register. s_axis_tready drops only
// while the output skid register holds a word; the pipeline then freezes in place.
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_fixed_point_alu_macros.svh"

// ----------------------------------------------------------------------------
// Decimal fixed-point ALU top level
// Pipelined add/sub/mul/div/mod/neg/compare/convert on integers and scaled decimals.
// ----------------------------------------------------------------------------
module decimal_fixed_point_alu #(
    parameter int SCALE = 1000
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // mode[3:0], a_value[35:4], b_value[67:36]
    input  wire logic [1:0]  s_axis_tuser,  // a_is_decimal[0], b_is_decimal[1]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // result_value[31:0]
    output logic [1:0]       m_axis_tuser   // result_is_decimal[0], error[1]
);

    localparam int NW = dfpa_pkg::NUM_W;
    localparam int DW = dfpa_pkg::DEN_W;
    localparam int QW = dfpa_pkg::QUO_W;
    localparam logic signed [31:0] SCALE_W   = 32'(SCALE);
    localparam logic signed [31:0] DIV_PRE_W = 32'(SCALE * 10);
    localparam logic signed [35:0] MUL_DIV_W = 36'((SCALE / 10) * 10);
    localparam logic signed [35:0] SCALE_D   = 36'(SCALE);

    logic ce;
    logic s_fire;

    // Stage 1: capture the word
    logic        p1_valid_reg;
    logic [3:0]  p1_mode_reg;
    logic signed [31:0] p1_a_reg, p1_b_reg;
    logic        p1_ad_reg, p1_bd_reg;

    // Stage 2: decimal-scaled operands
    logic        p2_valid_reg;
    logic [3:0]  p2_mode_reg;
    logic signed [31:0] p2_a_reg, p2_b_reg, p2_da_reg, p2_db_reg;
    logic        p2_ad_reg, p2_bd_reg;
    logic signed [63:0] a_scaled, b_scaled;

    // Stage 3: product and operand select
    logic        p3_valid_reg;
    logic signed [63:0] p3_prod_reg;
    logic signed [31:0] p3_nalt_reg;
    logic        p3_use_prod_reg;
    logic        p3_prod_low_reg;
    logic signed [35:0] p3_den_reg;
    dfpa_pkg::side_t p3_side_reg;

    logic signed [31:0] mul_x, mul_y;
    logic signed [63:0] prod_next;
    logic signed [31:0] nalt_next;
    logic        use_prod_next, prod_low_next, dec;
    logic signed [35:0] den_next;
    dfpa_pkg::side_t side_next;

    // Stage 4: magnitudes into the divider
    logic        p4_valid_reg;
    logic [NW-1:0] p4_num_reg;
    logic [DW-1:0] p4_den_reg;
    dfpa_pkg::side_t p4_side_reg;
    logic signed [63:0] num_full;
    logic [35:0] den_abs;
    dfpa_pkg::side_t p4_side_next;

    // Divider outputs
    logic          dv_valid;
    logic [QW-1:0] dv_quot;
    logic [DW-1:0] dv_rem;
    logic [DW-1:0] dv_den;
    dfpa_pkg::side_t dv_side;

    // Sign and rounding stage
    logic        f1_valid_reg;
    logic [31:0] f1_quot_reg, f1_rem_reg;
    logic        f1_carry_reg;
    dfpa_pkg::side_t f1_side_reg;
    logic        q_neg;

    // Output and skid registers
    logic        out_valid_reg, skid_valid_reg;
    logic [31:0] out_data_reg, skid_data_reg;
    logic [1:0]  out_user_reg, skid_user_reg;
    logic [31:0] res_value;
    logic        m_fire, f1_push;

    assign ce            = !skid_valid_reg;
    assign s_axis_tready = ce;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Valid bits of stages 1 to 4 and of the sign and rounding stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
        end else if (ce) begin
            p1_valid_reg <= s_fire;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            f1_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p1_mode_reg <= s_axis_tdata[3:0];
            p1_a_reg    <= s_axis_tdata[35:4];
            p1_b_reg    <= s_axis_tdata[67:36];
            p1_ad_reg   <= s_axis_tuser[0];
            p1_bd_reg   <= s_axis_tuser[1];
        end
    end

    // Scale integer operands to the decimal grid, wrapping to 32 bits
    assign a_scaled = p1_a_reg * SCALE_W;
    assign b_scaled = p1_b_reg * SCALE_W;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p2_mode_reg <= p1_mode_reg;
            p2_a_reg    <= p1_a_reg;
            p2_b_reg    <= p1_b_reg;
            p2_ad_reg   <= p1_ad_reg;
            p2_bd_reg   <= p1_bd_reg;
            p2_da_reg   <= p1_ad_reg ? p1_a_reg : a_scaled[31:0];
            p2_db_reg   <= p1_bd_reg ? p1_b_reg : b_scaled[31:0];
        end
    end

    // Decode the mode: multiplier operands, divider operands, simple results
    always_comb begin
        dec           = p2_ad_reg || p2_bd_reg;
        mul_x         = p2_da_reg;
        mul_y         = p2_db_reg;
        nalt_next     = p2_a_reg;
        use_prod_next = 1'b0;
        prod_low_next = 1'b0;
        den_next      = 36'(p2_b_reg);
        side_next     = '0;
        side_next.sel = dfpa_pkg::SEL_SIMPLE;
        case (p2_mode_reg)
            dfpa_pkg::MODE_ADD: begin
                side_next.rdec   = dec;
                side_next.simple = dec ? p2_da_reg + p2_db_reg : p2_a_reg + p2_b_reg;
            end
            dfpa_pkg::MODE_SUB: begin
                side_next.rdec   = dec;
                side_next.simple = dec ? p2_da_reg - p2_db_reg : p2_a_reg - p2_b_reg;
            end
            dfpa_pkg::MODE_MUL: begin
                side_next.rdec = dec;
                if (dec) begin
                    use_prod_next      = 1'b1;
                    den_next           = MUL_DIV_W;
                    side_next.sel      = dfpa_pkg::SEL_QUOT;
                    side_next.round_en = 1'b1;
                end else begin
                    mul_x         = p2_a_reg;
                    mul_y         = p2_b_reg;
                    prod_low_next = 1'b1;
                end
            end
            dfpa_pkg::MODE_DIV: begin
                side_next.rdec = dec;
                side_next.sel  = dfpa_pkg::SEL_QUOT;
                if (dec) begin
                    mul_y              = DIV_PRE_W;
                    use_prod_next      = 1'b1;
                    den_next           = 36'(p2_db_reg) * 36'sd10;
                    side_next.round_en = 1'b1;
                    side_next.err      = p2_db_reg == '0;
                end else begin
                    side_next.err = p2_b_reg == '0;
                end
            end
            dfpa_pkg::MODE_MOD: begin
                side_next.rdec = dec;
                side_next.sel  = dfpa_pkg::SEL_REM;
                nalt_next      = dec ? p2_da_reg : p2_a_reg;
                den_next       = dec ? 36'(p2_db_reg) : 36'(p2_b_reg);
                side_next.err  = dec ? p2_db_reg == '0 : p2_b_reg == '0;
            end
            dfpa_pkg::MODE_NEG: begin
                side_next.rdec   = p2_ad_reg;
                side_next.simple = -p2_a_reg;
            end
            dfpa_pkg::MODE_EQ: begin
                if (p2_ad_reg != p2_bd_reg) begin
                    side_next.simple = {31'd0, p2_da_reg == p2_db_reg};
                end else begin
                    side_next.simple = {31'd0, p2_a_reg == p2_b_reg};
                end
            end
            dfpa_pkg::MODE_LT: begin
                if (p2_ad_reg != p2_bd_reg) begin
                    side_next.simple = {31'd0, p2_da_reg < p2_db_reg};
                end else begin
                    side_next.simple = {31'd0, p2_a_reg < p2_b_reg};
                end
            end
            dfpa_pkg::MODE_TO_INT: begin
                side_next.simple = p2_a_reg;
                if (p2_ad_reg) begin
                    den_next      = SCALE_D;
                    side_next.sel = dfpa_pkg::SEL_QUOT;
                end
            end
            dfpa_pkg::MODE_TO_DEC: begin
                side_next.rdec   = 1'b1;
                side_next.simple = p2_da_reg;
            end
            default: begin
                side_next.simple = '0;
            end
        endcase
    end

    assign prod_next = mul_x * mul_y;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p3_prod_reg     <= prod_next;
            p3_nalt_reg     <= nalt_next;
            p3_use_prod_reg <= use_prod_next;
            p3_prod_low_reg <= prod_low_next;
            p3_den_reg      <= den_next;
            p3_side_reg     <= side_next;
        end
    end

    // Split dividend and divisor into sign and magnitude
    always_comb begin
        num_full             = p3_use_prod_reg ? p3_prod_reg : 64'(p3_nalt_reg);
        den_abs              = p3_den_reg[35] ? -p3_den_reg : p3_den_reg;
        p4_side_next         = p3_side_reg;
        p4_side_next.num_neg = num_full[63];
        p4_side_next.den_neg = p3_den_reg[35];
        if (p3_prod_low_reg) begin
            p4_side_next.simple = p3_prod_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p4_num_reg  <= num_full[63] ? -num_full : num_full;
            p4_den_reg  <= den_abs[DW-1:0];
            p4_side_reg <= p4_side_next;
        end
    end

    dfpa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (p4_valid_reg),
        .in_num    (p4_num_reg),
        .in_den    (p4_den_reg),
        .in_side   (p4_side_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_rem   (dv_rem),
        .out_den   (dv_den),
        .out_side  (dv_side)
    );

    // Restore signs; round a non-negative quotient up when the dropped digit is five or more
    assign q_neg = dv_side.num_neg ^ dv_side.den_neg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            f1_quot_reg  <= q_neg ? -dv_quot : dv_quot;
            f1_rem_reg   <= dv_side.num_neg ? -dv_rem[31:0] : dv_rem[31:0];
            f1_carry_reg <= dv_side.round_en && !q_neg && ({dv_rem, 1'b0} >= {1'b0, dv_den});
            f1_side_reg  <= dv_side;
        end
    end

    // Pick the result word; an error forces it to zero
    always_comb begin
        case (f1_side_reg.sel)
            dfpa_pkg::SEL_QUOT: res_value = f1_quot_reg + {31'd0, f1_carry_reg};
            dfpa_pkg::SEL_REM:  res_value = f1_rem_reg;
            default:            res_value = f1_side_reg.simple;
        endcase
        if (f1_side_reg.err) begin
            res_value = '0;
        end
    end

    assign m_fire  = m_axis_tvalid && m_axis_tready;
    assign f1_push = ce && f1_valid_reg;

    // Output register with skid: park a word when the output stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (f1_push) begin
            if (out_valid_reg && !m_fire) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end else if (f1_push) begin
            if (out_valid_reg && !m_fire) begin
                skid_data_reg <= res_value;
                skid_user_reg <= {f1_side_reg.err, f1_side_reg.rdec};
            end else begin
                out_data_reg <= res_value;
                out_user_reg <= {f1_side_reg.err, f1_side_reg.rdec};
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Checks
    `DFPA_ASSERT_NOW(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid word without output word")
    `DFPA_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == 32'd0, "error with nonzero value")
    `DFPA_ASSERT_NEXT(a_park, f1_push && out_valid_reg && !m_fire && !skid_valid_reg, skid_valid_reg, "stalled word not parked")

endmodule

`default_nettype wire

>>> test/decimal_fixed_point_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal fixed-point ALU testbench
// Drives directed and random operand words through the ALU, predicts each
// result with an independent fixed-point model and compares in order.
// ----------------------------------------------------------------------------

class alu_result_board;
    typedef struct {
        logic [31:0] value;
        logic        is_dec;
        logic        err;
    } alu_result_t;

    alu_result_t pending[$];
    int          n_errors;
    int          n_checked;

    function longint scale_up(longint v, bit is_dec);
        longint p;
        if (is_dec) return v;
        p = v * 1000;
        return longint'($signed(p[31:0]));
    endfunction

    function longint round_last_digit(longint x);
        longint q;
        q = x / 10;
        if (x % 10 >= 5) q = q + 1;
        return q;
    endfunction

    // Compute the expected result of one word and queue it
    function void note_word(dfpa_pkg::mode_t mode, logic [31:0] av, bit ad,
                            logic [31:0] bv, bit bd);
        alu_result_t r;
        longint a, b, da, db, res;
        bit any_dec;
        a = longint'($signed(av));
        b = longint'($signed(bv));
        any_dec = ad | bd;
        da = scale_up(a, ad);
        db = scale_up(b, bd);
        res = 0;
        r.is_dec = 0;
        r.err = 0;
        case (mode)
            dfpa_pkg::MODE_ADD: begin
                r.is_dec = any_dec;
                res = any_dec ? da + db : a + b;
            end
            dfpa_pkg::MODE_SUB: begin
                r.is_dec = any_dec;
                res = any_dec ? da - db : a - b;
            end
            dfpa_pkg::MODE_MUL: begin
                r.is_dec = any_dec;
                res = any_dec ? round_last_digit((da * db) / 100) : a * b;
            end
            dfpa_pkg::MODE_DIV: begin
                r.is_dec = any_dec;
                if ((any_dec ? db : b) == 0) r.err = 1;
                else if (any_dec) res = round_last_digit((da * 10000) / db);
                else res = a / b;
            end
            dfpa_pkg::MODE_MOD: begin
                r.is_dec = any_dec;
                if ((any_dec ? db : b) == 0) r.err = 1;
                else res = any_dec ? da % db : a % b;
            end
            dfpa_pkg::MODE_NEG: begin
                r.is_dec = ad;
                res = -a;
            end
            dfpa_pkg::MODE_EQ: res = (ad != bd) ? (da == db) : (a == b);
            dfpa_pkg::MODE_LT: res = (ad != bd) ? (da < db) : (a < b);
            dfpa_pkg::MODE_TO_INT: res = ad ? a / 1000 : a;
            dfpa_pkg::MODE_TO_DEC: begin
                r.is_dec = 1;
                res = da;
            end
            default: res = 0;
        endcase
        r.value = res[31:0];
        pending.insert(pending.size(), r);
    endfunction

    // Compare one result word with the oldest expectation
    function void check_word(logic [31:0] value, logic is_dec, logic err);
        alu_result_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result value=%h dec=%b err=%b",
                     $time, value, is_dec, err);
            n_errors++;
            return;
        end
        e = pending.pop_front();
        n_checked++;
        if (value !== e.value || is_dec !== e.is_dec || err !== e.err) begin
            $display("%0t: mismatch expected value=%h dec=%b err=%b, actual value=%h dec=%b err=%b",
                     $time, e.value, e.is_dec, e.err, value, is_dec, err);
            n_errors++;
        end
    endfunction
endclass

module decimal_fixed_point_alu_tb;

    localparam int LATENCY = 70;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    alu_result_board board;
    bit              calm;   // no idling on either side while set
    int              n_words;

    decimal_fixed_point_alu dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // Send one word; hold it until accepted, idle at random beforehand
    task automatic send_word(logic [3:0] mode, logic [31:0] av, bit ad,
                             logic [31:0] bv, bit bd);
        while (!calm && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {4'b0, bv, av, mode};
        s_axis_tuser  <= {bd, ad};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note_word(dfpa_pkg::mode_t'(mode), av, ad, bv, bd);
        n_words++;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return $urandom_range(20) - 10;
            1: return $urandom_range(20000) - 10000;
            2: return $urandom_range(2000000) - 1000000;
            3: return {$urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000} ^ $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // Sink side: random back-pressure, check each accepted word
    initial begin
        m_axis_tready = 0;
        forever begin
            @(negedge aclk);
            m_axis_tready <= calm || ($urandom_range(99) >= 15);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_word(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
    end

    initial begin
        #20ms;
        $display("decimal_fixed_point_alu_tb: errors");
        $finish;
    end

    initial begin
        logic [31:0] edges [6];
        int          k;
        int          drain;
        board = new();
        calm = 0;
        n_words = 0;
        aresetn = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        edges = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'd1500};
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: every mode, extremes, zero divisors, rounding, unused modes
        for (int m = 0; m < 16; m++)
            send_word(4'(m), edges[m % 6], m[0], edges[(m + 3) % 6], m[1]);
        send_word(dfpa_pkg::MODE_DIV, 32'h80000000, 0, 32'hFFFFFFFF, 0);
        send_word(dfpa_pkg::MODE_MOD, 32'h80000000, 0, 32'hFFFFFFFF, 0);
        send_word(dfpa_pkg::MODE_DIV, 32'd5, 1, 32'd0, 0);
        send_word(dfpa_pkg::MODE_MOD, 32'd7, 0, 32'd0, 1);
        send_word(dfpa_pkg::MODE_MUL, 32'd1005, 1, 32'd500, 1);
        send_word(dfpa_pkg::MODE_MUL, -32'd1005, 1, 32'd500, 1);
        send_word(dfpa_pkg::MODE_TO_DEC, 32'h7FFFFFFF, 0, 32'd0, 0);
        send_word(dfpa_pkg::MODE_EQ, 32'd2, 0, 32'd2000, 1);
        send_word(dfpa_pkg::MODE_TO_INT, -32'd2999, 1, 32'd0, 0);
        s_axis_tvalid <= 0;

        // Pause until everything in flight has returned
        while (board.pending.size() != 0) @(negedge aclk);

        for (k = 0; k < 1400; k++) begin
            calm = (k >= 500 && k < 700);
            send_word(4'($urandom_range(99) < 95 ? $urandom_range(9) : $urandom_range(15)),
                      rand_operand(), 1'($urandom_range(1)),
                      rand_operand(), 1'($urandom_range(1)));
        end
        calm = 0;
        s_axis_tvalid <= 0;

        while (board.pending.size() != 0) @(negedge aclk);
        drain = 0;
        while (drain < 2 * LATENCY) begin
            @(negedge aclk);
            drain++;
        end

        $display("Sent %0d words over all modes, tags and operand extremes; %0d results checked.",
                 n_words, board.n_checked);
        if (board.n_errors == 0)
            $display("decimal_fixed_point_alu_tb: clean");
        else
            $display("decimal_fixed_point_alu_tb: errors");
        $finish;
    end
endmodule
